### src/srt_pkg.sv
// Shared types and constants for the sorted result table.
package srt_pkg;

   localparam int RACE_W   = 10;
   localparam int RUNNER_W = 8;
   localparam int TIME_W   = 20;
   localparam int RANK_W   = 7;
   localparam int RANK_MAX = 127;

   // Beat operation codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [RACE_W-1:0]   race_id;
      logic [RUNNER_W-1:0] runner;
      logic [TIME_W-1:0]   time_hundredths;
   } entry_type;

   // Query token walking down the row of cells
   typedef struct packed {
      logic valid;
      logic done;
   } tok_type;

endpackage

### src/srt_cell.sv
// One table slot: holds an entry, shifts on insert and passes the query token on.
module srt_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    count,
   input  logic                ins_en,
   input  srt_pkg::entry_type  key,
   input  srt_pkg::entry_type  left_entry,
   input  logic                left_after,
   output srt_pkg::entry_type  my_entry,
   output logic                my_after,
   input  srt_pkg::tok_type    tok_in,
   input  logic [CNT_W-1:0]    n_in,
   output srt_pkg::tok_type    tok_out,
   output logic [CNT_W-1:0]    n_out
);
   import srt_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   entry_type        entry_ff, entry_in;
   tok_type          tok_ff, tok_in_nx;
   logic [CNT_W-1:0] n_ff, n_in_nx;
   logic             cell_valid;
   logic             hit;
   logic             match;

   assign cell_valid = count > IDX;

   // New entry goes behind this slot when we sort before or tie with it
   assign my_after = cell_valid &&
                     (entry_ff.race_id < key.race_id ||
                      (entry_ff.race_id == key.race_id &&
                       entry_ff.time_hundredths >= key.time_hundredths));

   // Insert: keep, take the new entry, or take the left neighbour's
   always_comb begin
      entry_in = entry_ff;
      if (ins_en && !my_after) begin
         entry_in = left_after ? key : left_entry;
      end
   end

   // Query: count same-race entries until the runner is found
   assign hit   = tok_in.valid && !tok_in.done && cell_valid &&
                  entry_ff.race_id == key.race_id;
   assign match = entry_ff.runner == key.runner;

   always_comb begin
      tok_in_nx.valid = tok_in.valid;
      tok_in_nx.done  = tok_in.done | (hit & match);
      n_in_nx         = (hit && !match) ? n_in + CNT_W'(1) : n_in;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      n_ff     <= n_in_nx;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign my_entry = entry_ff;
   assign tok_out  = tok_ff;
   assign n_out    = n_ff;

endmodule

### src/sorted_result_table.sv
// Top level: sorted race result table with rank queries, built as a row of cells.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  request  req_mode req_race_id req_runner         start high, busy low
//           req_time_hundredths
//  result   rsp_rank rsp_status                     rsp_strobe, one cycle
//
// An insert holds busy while every cell compares in parallel and the row
// shifts in one step. A query holds busy while a token walks the row one
// cell per cycle, counting same-race entries.
// The result strobe rises on the edge that clears busy; the receiver cannot stall.
// Synchronous reset empties the table (entry count zero) and idles the block.
module sorted_result_table #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [srt_pkg::RACE_W-1:0]    req_race_id,
   input  logic [srt_pkg::RUNNER_W-1:0]  req_runner,
   input  logic [srt_pkg::TIME_W-1:0]    req_time_hundredths,
   output logic                          rsp_strobe,
   output logic [srt_pkg::RANK_W-1:0]    rsp_rank,
   output logic                          rsp_status
);
   import srt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SAT_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   logic             busy_ff, busy_in;
   logic             launch_ff, launch_in;
   logic             mode_ff;
   entry_type        key_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             strobe_ff, strobe_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic             status_ff, status_in;

   logic             accept;
   logic             full;
   logic             ins_en;
   logic [SAT_W-1:0] n_ext;

   entry_type        entry_w [CAPACITY];
   logic             after_w [CAPACITY];
   tok_type          tok_w   [CAPACITY+1];
   logic [CNT_W-1:0] n_w     [CAPACITY+1];

   assign accept = start && !busy_ff;
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign ins_en = launch_ff && mode_ff == MODE_INSERT && !full;

   // Token enters the first cell in the cycle after a query is taken
   assign tok_w[0].valid = launch_ff && mode_ff == MODE_QUERY;
   assign tok_w[0].done  = 1'b0;
   assign n_w[0]         = '0;

   // Row of cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      srt_cell #(
         .CNT_W (CNT_W),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .ins_en     (ins_en),
         .key        (key_ff),
         .left_entry ((g == 0) ? key_ff : entry_w[(g == 0) ? 0 : g-1]),
         .left_after ((g == 0) ? 1'b1 : after_w[(g == 0) ? 0 : g-1]),
         .my_entry   (entry_w[g]),
         .my_after   (after_w[g]),
         .tok_in     (tok_w[g]),
         .n_in       (n_w[g]),
         .tok_out    (tok_w[g+1]),
         .n_out      (n_w[g+1])
      );
   end

   // Widen the rank count so it can be saturated to the result field
   assign n_ext = SAT_W'(n_w[CAPACITY]);

   // Control and result register
   always_comb begin
      busy_in   = busy_ff;
      launch_in = accept;
      count_in  = count_ff;
      strobe_in = 1'b0;
      rank_in   = rank_ff;
      status_in = status_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (launch_ff && mode_ff == MODE_INSERT) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
         rank_in   = '0;
         status_in = full ? STATUS_FULL : STATUS_OK;
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (tok_w[CAPACITY].valid) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
         status_in = STATUS_OK;
         rank_in   = (n_ext > SAT_W'(RANK_MAX)) ? RANK_W'(RANK_MAX) : n_ext[RANK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rank_ff   <= rank_in;
      status_ff <= status_in;
      if (accept) begin
         mode_ff                <= req_mode;
         key_ff.race_id         <= req_race_id;
         key_ff.runner          <= req_runner;
         key_ff.time_hundredths <= req_time_hundredths;
      end
      if (reset) begin
         busy_ff   <= 1'b0;
         launch_ff <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_rank   = rank_ff;
   assign rsp_status = status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      ins_en |=> rsp_strobe && rsp_status == STATUS_OK)
      else $error("accepted insert flagged as dropped");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      tok_w[CAPACITY].valid |-> busy_ff && mode_ff == MODE_QUERY)
      else $error("query token out while idle");

   a_accept_launch: assert property (@(posedge clock) disable iff (reset)
      accept |=> launch_ff && busy_ff && !rsp_strobe)
      else $error("accepted beat not launched");

endmodule
